[rtl/tli_pkg.sv]
package tli_pkg;

	localparam int DEF_TABLE_POINTS = 256;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;
	localparam logic [1:0] REQ_NOP    = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_NOT_INC = 3'd2;
	localparam logic [2:0] ST_FEW     = 3'd3;
	localparam logic [2:0] ST_SAT     = 3'd4;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] x;
		logic signed [31:0] v;
	} cmd_t;

endpackage

[rtl/table_linear_interpolator_top.sv]
// Piecewise linear interpolator over a table of up to TABLE_POINTS Q16.16
// points (x, f(x)), appended with strictly increasing x. Issue a request by
// raising start while busy is low; a two-entry command queue takes requests
// while the executor works, and busy rises only when that queue is full.
// Every request yields exactly one result, shown for a single cycle with
// done high; results come in request order and must be taken then, since
// the block cannot hold them. Clear, append and unused codes finish in
// the S_EXEC state. A query with two or more points runs a binary search
// over the x memory, each probe passing S_SRCH and S_CMP on its single
// registered read port, then the 64-step restoring divider that forms the
// rounded slope product, which dominates the query time.
// Below the first point the first segment is extended, beyond the last the
// last one; out-of-range results clamp and report saturation.
module table_linear_interpolator_top import tli_pkg::*; #(
	parameter int TABLE_POINTS = DEF_TABLE_POINTS,
	localparam int CW = $clog2(TABLE_POINTS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_value,
	output logic               done,
	output logic signed [31:0] value,
	output logic [2:0]         status,
	output logic [CW-1:0]      points_held
);

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	tli_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.point_x     (point_x),
		.point_value (point_value),
		.busy        (busy),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	tli_exec #(
		.TABLE_POINTS (TABLE_POINTS)
	) u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop),
		.done        (done),
		.value       (value),
		.status      (status),
		.points_held (points_held)
	);

endmodule

[rtl/tli_front.sv]
module tli_front import tli_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_value,
	output logic               busy,
	output logic               cmd_valid,
	output cmd_t               cmd,
	input  logic               cmd_pop
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	cmd_t       in_cmd;

	always_comb begin
		in_cmd.x = point_x;
		in_cmd.v = point_value;
		unique case (req_type)
			REQ_CLEAR:  in_cmd.op = REQ_CLEAR;
			REQ_APPEND: in_cmd.op = REQ_APPEND;
			REQ_QUERY:  in_cmd.op = REQ_QUERY;
			default:    in_cmd.op = REQ_NOP;
		endcase
	end

	assign busy      = (fill_q == 2'd2);
	assign push      = start && !busy;
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(cmd_pop);
		end
	end

endmodule

[rtl/tli_exec.sv]
module tli_exec import tli_pkg::*; #(
	parameter int TABLE_POINTS = DEF_TABLE_POINTS,
	localparam int AW = $clog2(TABLE_POINTS),
	localparam int CW = $clog2(TABLE_POINTS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  cmd_t               cmd,
	output logic               cmd_pop,
	output logic               done,
	output logic signed [31:0] value,
	output logic [2:0]         status,
	output logic [CW-1:0]      points_held
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_SRCH = 4'd2;
	localparam logic [3:0] S_CMP  = 4'd3;
	localparam logic [3:0] S_RDL  = 4'd4;
	localparam logic [3:0] S_DIFF = 4'd5;
	localparam logic [3:0] S_MUL  = 4'd6;
	localparam logic [3:0] S_ADD  = 4'd7;
	localparam logic [3:0] S_DIV  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;

	logic signed [31:0] x_mem [TABLE_POINTS];
	logic signed [31:0] v_mem [TABLE_POINTS];

	logic [3:0]         state_q;
	cmd_t               cur_q;
	logic [CW-1:0]      count_q;
	logic signed [31:0] last_x_q;
	logic [CW-1:0]      lo_q, hi_q;
	logic [AW-1:0]      mid_q;
	logic [AW-1:0]      l_idx_q;
	logic               base_hi_q;
	logic signed [31:0] x_rd_q, v_rd_q;
	logic signed [31:0] xh_q, vh_q, vbase_q;
	logic [31:0]        mdy_q, mdt_q, dx_q;
	logic               neg_q;
	logic [63:0]        prod_q;
	logic [63:0]        num_q;
	logic [31:0]        rem_q;
	logic [5:0]         step_q;
	logic               done_q;
	logic signed [31:0] value_q;
	logic [2:0]         status_q;

	logic [AW-1:0]      rd_addr;
	logic [CW:0]        mid_sum;
	logic [CW-1:0]      l_full, h_full;
	logic               seg_base_hi;
	logic signed [32:0] dy, dx, dt;
	logic signed [31:0] x_base;
	logic [32:0]        rem_sh;
	logic               q_bit;
	logic signed [41:0] r_sum;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

	// segment from search result lo_q (first index with x above query)
	always_comb begin
		if (lo_q == count_q) begin
			l_full      = count_q - CW'(2);
			h_full      = count_q - CW'(1);
			seg_base_hi = 1'b1;
		end else if (lo_q == '0) begin
			l_full      = '0;
			h_full      = CW'(1);
			seg_base_hi = 1'b0;
		end else begin
			l_full      = lo_q - CW'(1);
			h_full      = lo_q;
			seg_base_hi = 1'b0;
		end
	end

	always_comb begin
		priority if (state_q == S_SRCH && lo_q != hi_q) begin
			rd_addr = mid_sum[AW:1];
		end else if (state_q == S_SRCH) begin
			rd_addr = h_full[AW-1:0];
		end else begin
			rd_addr = l_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && cur_q.op == REQ_APPEND && count_q != CW'(TABLE_POINTS)
		    && !(count_q != '0 && cur_q.x <= last_x_q)) begin
			x_mem[count_q[AW-1:0]] <= cur_q.x;
			v_mem[count_q[AW-1:0]] <= cur_q.v;
		end
		x_rd_q <= x_mem[rd_addr];
		v_rd_q <= v_mem[rd_addr];
	end

	assign x_base = base_hi_q ? xh_q : x_rd_q;
	assign dy     = 33'(vh_q) - 33'(v_rd_q);
	assign dx     = 33'(xh_q) - 33'(x_rd_q);
	assign dt     = 33'(cur_q.x) - 33'(x_base);
	assign rem_sh = {rem_q, num_q[63]};
	assign q_bit  = (rem_sh >= {1'b0, dx_q});
	assign r_sum  = 42'(vbase_q) + (neg_q ? -$signed({1'b0, num_q[40:0]})
	                                      : $signed({1'b0, num_q[40:0]}));

	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cur_q <= cmd;
				end
			end
			S_EXEC: begin
				lo_q <= '0;
				hi_q <= count_q;
			end
			S_SRCH: begin
				mid_q     <= rd_addr;
				l_idx_q   <= l_full[AW-1:0];
				base_hi_q <= seg_base_hi;
			end
			S_CMP: begin
				if (x_rd_q > cur_q.x) begin
					hi_q <= CW'(mid_q);
				end else begin
					lo_q <= CW'(mid_q) + CW'(1);
				end
			end
			S_RDL: begin
				xh_q <= x_rd_q;
				vh_q <= v_rd_q;
			end
			S_DIFF: begin
				mdy_q   <= dy[32] ? 32'(-dy) : dy[31:0];
				mdt_q   <= dt[32] ? 32'(-dt) : dt[31:0];
				dx_q    <= dx[31:0];
				neg_q   <= dy[32] ^ dt[32];
				vbase_q <= base_hi_q ? vh_q : v_rd_q;
			end
			S_MUL: begin
				prod_q <= mdy_q * mdt_q;
			end
			S_ADD: begin
				num_q  <= prod_q + 64'(dx_q >> 1);
				rem_q  <= '0;
				step_q <= '0;
			end
			S_DIV: begin
				rem_q  <= q_bit ? 32'(rem_sh - {1'b0, dx_q}) : rem_sh[31:0];
				num_q  <= {num_q[62:0], q_bit};
				step_q <= step_q + 6'd1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			last_x_q <= '0;
			done_q   <= 1'b0;
			value_q  <= '0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					value_q  <= '0;
					status_q <= ST_OK;
					state_q  <= S_IDLE;
					done_q   <= 1'b1;
					unique case (cur_q.op)
						REQ_CLEAR: begin
							count_q <= '0;
						end
						REQ_APPEND: begin
							priority if (count_q == CW'(TABLE_POINTS)) begin
								status_q <= ST_FULL;
							end else if (count_q != '0 && cur_q.x <= last_x_q) begin
								status_q <= ST_NOT_INC;
							end else begin
								count_q  <= count_q + CW'(1);
								last_x_q <= cur_q.x;
							end
						end
						REQ_QUERY: begin
							if (count_q < CW'(2)) begin
								status_q <= ST_FEW;
							end else begin
								done_q  <= 1'b0;
								state_q <= S_SRCH;
							end
						end
						default: begin
						end
					endcase
				end
				S_SRCH: state_q <= (lo_q == hi_q) ? S_RDL : S_CMP;
				S_CMP:  state_q <= S_SRCH;
				S_RDL:  state_q <= S_DIFF;
				S_DIFF: state_q <= S_MUL;
				S_MUL:  state_q <= S_ADD;
				S_ADD:  state_q <= S_DIV;
				S_DIV: begin
					if (step_q == 6'd63) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					priority if (num_q > (64'd1 << 40)) begin
						value_q  <= neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
						status_q <= ST_SAT;
					end else if (r_sum > 42'sd2147483647) begin
						value_q  <= 32'sh7fff_ffff;
						status_q <= ST_SAT;
					end else if (r_sum < -42'sd2147483648) begin
						value_q  <= 32'sh8000_0000;
						status_q <= ST_SAT;
					end else begin
						value_q  <= r_sum[31:0];
						status_q <= ST_OK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done        = done_q;
	assign value       = value_q;
	assign status      = status_q;
	assign points_held = count_q;

endmodule

[rtl/tli_checker.sv]
module tli_checker import tli_pkg::*; #(
	parameter int TABLE_POINTS = DEF_TABLE_POINTS,
	localparam int CW = $clog2(TABLE_POINTS + 1)
) (
	input logic               clk,
	input logic               arst_n,
	input logic               done,
	input logic signed [31:0] value,
	input logic [2:0]         status,
	input logic [CW-1:0]      points_held
);

	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result beats");

	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FEW |-> value == '0 && points_held < CW'(2))
		else $error("too-few result with value or count wrong");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> points_held == CW'(TABLE_POINTS))
		else $error("full status with table not full");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_SAT |-> value == 32'sh7fff_ffff || value == 32'sh8000_0000)
		else $error("saturated result not at a bound");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status <= ST_SAT)
		else $error("undefined status code");

endmodule

bind table_linear_interpolator_top tli_checker #(
	.TABLE_POINTS (TABLE_POINTS)
) u_tli_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.done        (done),
	.value       (value),
	.status      (status),
	.points_held (points_held)
);
